### hdl/spmq_pkg.sv
// Shared types and constants for the strict priority multi-queue.
// Used by the top level, the port checker and the testbench; no dependencies.
package spmq_pkg;

  // Fixed widths of the transaction fields
  localparam int PRIO_W       = 8;
  localparam int HANDLE_W     = 16;
  localparam int LEVEL_PORT_W = 3;
  localparam int STATUS_W     = 3;

  // Request kinds
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ENQ    = 3'd0,
    ST_FULL   = 3'd1,
    ST_NOCONS = 3'd2,
    ST_DEQ    = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

endpackage

### hdl/spmq_pick.sv
// Priority encoder that picks the lowest-numbered non-empty level.
// Depends on nothing but its parameters.
module spmq_pick #(
  parameter int NUM_LEVELS = 8,
  parameter int LW         = 3
) (
  input  logic [NUM_LEVELS-1:0] nonempty,
  output logic                  found,
  output logic [LW-1:0]         level
);

  // Scan from the highest level downward; the last hit, the lowest level, wins
  always_comb begin
    found = 1'b0;
    level = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        found = 1'b1;
        level = LW'(i);
      end
    end
  end

endmodule

### hdl/strict_priority_multi_queue.sv
// Strict priority multi-queue: one handle FIFO per priority level, level 0 served first.
// Depends on spmq_pkg and spmq_pick.
//
// The block takes one enqueue or dequeue transaction in every cycle (start while
// busy is low) and returns exactly one result in the next cycle, marked by done for a
// single cycle; the receiver cannot stall it. The dequeued handle is taken from the
// registered read port of the handle memory, which holds all levels in one array of
// (MAX_PRIORITY+1)*LEVEL_DEPTH entries. Occupancy counts and head pointers sit in
// flip-flops, so no clearing pass follows reset. busy is high only during reset.
// The consumers_ready register resets to 1 and is written through cfg_valid/cfg_ready.
module strict_priority_multi_queue
  import spmq_pkg::*;
#(
  parameter int MAX_PRIORITY = 7,
  parameter int LEVEL_DEPTH  = 16,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    kind,
  input  logic [PRIO_W-1:0]       priority_req,
  input  logic [HANDLE_W-1:0]     packet_handle,
  output logic                    done,
  output logic [STATUS_W-1:0]     status,
  output logic [HANDLE_W-1:0]     out_handle,
  output logic [LEVEL_PORT_W-1:0] out_level,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_data
);

  localparam int NUM_LEVELS = MAX_PRIORITY + 1;
  localparam int LW         = $clog2(NUM_LEVELS);
  localparam int PW         = $clog2(LEVEL_DEPTH);
  localparam int CW         = $clog2(LEVEL_DEPTH + 1);
  localparam int DEPTH      = NUM_LEVELS * LEVEL_DEPTH;
  localparam int AW         = $clog2(DEPTH);
  localparam int SW         = (HANDLE_WIDTH < HANDLE_W) ? HANDLE_WIDTH : HANDLE_W;

  // Control state
  logic                  consumers_ready;
  logic [CW-1:0]         level_counts [NUM_LEVELS];
  logic [PW-1:0]         head_pointers [NUM_LEVELS];

  // Handle memory
  logic [SW-1:0]         level_store [DEPTH];
  logic [SW-1:0]         rd_data;

  // Result register
  logic                  done_r;
  status_t               status_r;
  logic [LW-1:0]         level_r;

  // Per-transaction decode
  logic                  accept;
  logic [LW-1:0]         enq_level;
  logic                  deq_found;
  logic [LW-1:0]         deq_level;
  logic [LW-1:0]         sel_level;
  logic [CW-1:0]         sel_count;
  logic [PW-1:0]         sel_head;
  logic [NUM_LEVELS-1:0] nonempty;
  logic [PW:0]           tail_sum;
  logic [PW-1:0]         tail;
  logic [PW-1:0]         head_inc;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_addr;
  logic [CW-1:0]         count_next;
  logic [PW-1:0]         head_next;
  logic                  upd_count;
  logic                  upd_head;
  status_t               status_next;
  logic [LW-1:0]         level_next;
  logic [LW+LEVEL_PORT_W-1:0] level_pad;
  logic [SW+HANDLE_W-1:0]     handle_pad;

  assign busy      = rst;
  assign cfg_ready = ~rst;
  assign accept    = start & ~busy;

  // Clamp the requested priority to the lowest level
  assign enq_level = (priority_req >= PRIO_W'(MAX_PRIORITY)) ? LW'(MAX_PRIORITY)
                                                             : priority_req[LW-1:0];

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      nonempty[i] = (level_counts[i] != '0);
    end
  end

  spmq_pick #(
    .NUM_LEVELS(NUM_LEVELS),
    .LW        (LW)
  ) u_pick (
    .nonempty(nonempty),
    .found   (deq_found),
    .level   (deq_level)
  );

  // Look up the one level this transaction touches
  assign sel_level = (kind == KIND_ENQ) ? enq_level : deq_level;
  assign sel_count = level_counts[sel_level];
  assign sel_head  = head_pointers[sel_level];

  // Tail slot and advanced head, both wrapping at LEVEL_DEPTH
  assign tail_sum = {1'b0, sel_head} + {1'b0, sel_count[PW-1:0]};
  assign tail     = (tail_sum >= (PW+1)'(LEVEL_DEPTH)) ?
                    PW'(tail_sum - (PW+1)'(LEVEL_DEPTH)) : tail_sum[PW-1:0];
  assign head_inc = (sel_head == PW'(LEVEL_DEPTH - 1)) ? '0 : sel_head + 1'b1;

  // Decide the outcome and the state update
  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    upd_count   = 1'b0;
    upd_head    = 1'b0;
    count_next  = sel_count;
    head_next   = sel_head;
    status_next = ST_EMPTY;
    level_next  = '0;
    mem_addr    = AW'(sel_level) * AW'(LEVEL_DEPTH) + AW'(sel_head);
    if (kind == KIND_ENQ) begin
      level_next = enq_level;
      mem_addr   = AW'(sel_level) * AW'(LEVEL_DEPTH) + AW'(tail);
      if (!consumers_ready) begin
        status_next = ST_NOCONS;
      end else if (sel_count == CW'(LEVEL_DEPTH)) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_ENQ;
        mem_we      = accept;
        upd_count   = accept;
        count_next  = sel_count + 1'b1;
      end
    end else if (deq_found) begin
      status_next = ST_DEQ;
      level_next  = deq_level;
      mem_re      = accept;
      upd_count   = accept;
      upd_head    = accept;
      count_next  = sel_count - 1'b1;
      head_next   = head_inc;
    end
  end

  // Hold counts, heads and the consumer flag
  always_ff @(posedge clk) begin
    if (rst) begin
      consumers_ready <= 1'b1;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        level_counts[i]  <= '0;
        head_pointers[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        consumers_ready <= cfg_data;
      end
      if (upd_count) begin
        level_counts[sel_level] <= count_next;
      end
      if (upd_head) begin
        head_pointers[sel_level] <= head_next;
      end
    end
  end

  // Write the enqueued handle, read the dequeued one
  always_ff @(posedge clk) begin
    if (mem_we) begin
      level_store[mem_addr] <= packet_handle[SW-1:0];
    end
    if (mem_re) begin
      rd_data <= level_store[mem_addr];
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done_r <= 1'b0;
    end else begin
      done_r <= accept;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_next;
      level_r  <= level_next;
    end
  end

  assign level_pad  = {{LEVEL_PORT_W{1'b0}}, level_r};
  assign handle_pad = {{HANDLE_W{1'b0}}, rd_data};

  assign done       = done_r;
  assign status     = status_r;
  assign out_level  = level_pad[LEVEL_PORT_W-1:0];
  assign out_handle = (status_r == ST_DEQ) ? handle_pad[HANDLE_W-1:0] : '0;

endmodule

### hdl/spmq_checker.sv
// Port-level checks for the strict priority multi-queue, attached by bind.
// Depends on spmq_pkg and on the strict_priority_multi_queue ports.
module spmq_checker
  import spmq_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    done,
  input logic [STATUS_W-1:0]     status,
  input logic [HANDLE_W-1:0]     out_handle,
  input logic [LEVEL_PORT_W-1:0] out_level
);

  // Every accepted transaction gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted transaction produced no result");

  // No result without a transaction the cycle before
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without an accepted transaction");

  // Only a dequeue carries a handle
  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_DEQ) |-> (out_handle == '0))
    else $error("handle shown on a result that is not a dequeue");

  // An empty report names level zero
  a_empty_level: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (out_level == '0))
    else $error("empty result with a nonzero level");

endmodule

bind strict_priority_multi_queue spmq_checker u_spmq_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .out_handle(out_handle),
  .out_level (out_level)
);

### tb/tb_strict_priority_multi_queue.sv
// Testbench for strict_priority_multi_queue: self-checking, with its own queue predictor.
// Depends on spmq_pkg and the strict_priority_multi_queue RTL; no other files.
module tb_strict_priority_multi_queue;
  import spmq_pkg::*;

  localparam int MAX_PRIO    = 7;
  localparam int NUM_LEVELS  = MAX_PRIO + 1;
  localparam int LEVEL_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    status_t                   status;
    logic [HANDLE_W-1:0]       handle;
    logic [LEVEL_PORT_W-1:0]   level;
  } queue_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    kind = KIND_ENQ;
  logic [PRIO_W-1:0]       priority_req = '0;
  logic [HANDLE_W-1:0]     packet_handle = '0;
  logic                    done;
  logic [STATUS_W-1:0]     status;
  logic [HANDLE_W-1:0]     out_handle;
  logic [LEVEL_PORT_W-1:0] out_level;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_data = 1'b0;

  // Predicted queue contents and configuration
  logic [HANDLE_W-1:0] level_mem [NUM_LEVELS][LEVEL_DEPTH];
  int unsigned         rd_ptr [NUM_LEVELS];
  int unsigned         fill [NUM_LEVELS];
  bit                  consumers_on = 1'b1;

  queue_result_t pending_results [$];
  queue_result_t head_exp;
  int            mismatch_count = 0;
  int            cycle_count = 0;

  strict_priority_multi_queue #(
    .MAX_PRIORITY(MAX_PRIO),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .HANDLE_WIDTH(HANDLE_W)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .priority_req (priority_req),
    .packet_handle(packet_handle),
    .done         (done),
    .status       (status),
    .out_handle   (out_handle),
    .out_level    (out_level),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Apply one transaction to the predicted queues and queue up its result
  function automatic void predict_queue_op(input logic k, input logic [PRIO_W-1:0] p,
                                           input logic [HANDLE_W-1:0] h);
    queue_result_t res;
    int            lvl;
    bit            found;
    res   = '{status: ST_EMPTY, handle: '0, level: '0};
    found = 1'b0;
    if (k == KIND_ENQ) begin
      // clamp oversized priorities to the lowest level
      lvl = (int'(p) < MAX_PRIO) ? int'(p) : MAX_PRIO;
      res.level = lvl[LEVEL_PORT_W-1:0];
      if (!consumers_on) begin
        res.status = ST_NOCONS;
      end else if (fill[lvl] >= LEVEL_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        level_mem[lvl][(rd_ptr[lvl] + fill[lvl]) % LEVEL_DEPTH] = h;
        fill[lvl]++;
        res.status = ST_ENQ;
      end
    end else begin
      // pop the lowest-numbered non-empty level
      for (lvl = 0; lvl < NUM_LEVELS; lvl++) begin
        if (!found && fill[lvl] != 0) begin
          found      = 1'b1;
          res.status = ST_DEQ;
          res.handle = level_mem[lvl][rd_ptr[lvl]];
          res.level  = lvl[LEVEL_PORT_W-1:0];
          rd_ptr[lvl] = (rd_ptr[lvl] + 1) % LEVEL_DEPTH;
          fill[lvl]--;
        end
      end
    end
    pending_results.insert(pending_results.size(), res);
  endfunction

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d handle=%h level=%0d",
                                  status, out_handle, out_level));
      end else begin
        head_exp = pending_results.pop_front();
        if (status !== head_exp.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, head_exp.status));
        if (out_handle !== head_exp.handle)
          report_mismatch($sformatf("out_handle %h, expected %h", out_handle,
                                    head_exp.handle));
        if (out_level !== head_exp.level)
          report_mismatch($sformatf("out_level %0d, expected %0d", out_level,
                                    head_exp.level));
      end
    end
  end

  // Drive one transaction after a random gap; leave start high for the next one
  task automatic send_op(input logic k, input logic [PRIO_W-1:0] p,
                         input logic [HANDLE_W-1:0] h, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    kind          <= k;
    priority_req  <= p;
    packet_handle <= h;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_queue_op(k, p, h);
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every predicted result has come back, plus the read latency
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_consumers(input bit value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    consumers_on = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_empty_dequeue();
    send_op(KIND_DEQ, 8'hFF, 16'hFFFF, 0);
    send_op(KIND_DEQ, 8'h00, 16'h0000, 0);
    release_start();
  endtask

  // One handle per level in reverse order, clamped priorities, then drain
  task automatic test_priority_levels();
    for (int p = MAX_PRIO; p >= 0; p--)
      send_op(KIND_ENQ, p[PRIO_W-1:0], 16'h1000 + 16'(p), 0);
    send_op(KIND_ENQ, 8'd8, 16'hFFFF, 0);
    send_op(KIND_ENQ, 8'd255, 16'h0000, 0);
    repeat (NUM_LEVELS + 3) send_op(KIND_DEQ, 8'(($urandom_range(255))), 16'hA5A5, 0);
    release_start();
  endtask

  // Overfill the lowest level across the pointer wrap, then drain it
  task automatic test_level_full();
    for (int i = 0; i <= LEVEL_DEPTH; i++)
      send_op(KIND_ENQ, (i % 2) ? 8'd200 : 8'd7, 16'($urandom_range(65535)), 0);
    repeat (LEVEL_DEPTH + 1) send_op(KIND_DEQ, 8'd0, 16'h0000, 0);
    release_start();
  endtask

  // Drop enqueues with no consumer; dequeues still proceed
  task automatic test_no_consumer();
    send_op(KIND_ENQ, 8'd3, 16'hBEEF, 0);
    send_op(KIND_ENQ, 8'd0, 16'h1234, 0);
    release_start();
    write_consumers(1'b0);
    send_op(KIND_ENQ, 8'd0, 16'h5555, 0);
    send_op(KIND_ENQ, 8'd255, 16'hAAAA, 0);
    send_op(KIND_ENQ, 8'd4, 16'h00FF, 0);
    repeat (3) send_op(KIND_DEQ, 8'd1, 16'h0F0F, 0);
    release_start();
    write_consumers(1'b1);
  endtask

  // Random traffic in bursts that lean toward filling or toward draining
  task automatic drive_traffic(input int count, input int idle_pct);
    int          enq_pct;
    int          sel;
    logic [PRIO_W-1:0] p;
    enq_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        sel = $urandom_range(2);
        enq_pct = (sel == 0) ? 20 : (sel == 1) ? 50 : 85;
      end
      sel = $urandom_range(99);
      if (sel < 60)      p = 8'($urandom_range(MAX_PRIO));
      else if (sel < 75) p = 8'($urandom_range(255, MAX_PRIO + 1));
      else               p = 8'($urandom_range(1));
      send_op(($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ, p,
              16'($urandom_range(65535)), idle_pct);
    end
    release_start();
  endtask

  task automatic test_random_traffic();
    drive_traffic(200, 0);
    write_consumers(1'b0);
    drive_traffic(50, 64);
    write_consumers(1'b1);
    drive_traffic(175, 64);
    drive_traffic(175, 22);
  endtask

  initial begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      rd_ptr[l] = 0;
      fill[l]   = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_dequeue();
    test_priority_levels();
    test_level_full();
    test_no_consumer();
    test_random_traffic();

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
